[hdl/sas_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package sas_pkg;

  localparam int unsigned NumAnimations = 8;
  localparam int unsigned MaxFrames = 16;

  typedef enum logic [2:0] {
    OP_TICK  = 3'd0,
    OP_PLAY  = 3'd1,
    OP_STOP  = 3'd2,
    OP_WRFR  = 3'd3,
    OP_WRDS  = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    MODE_LOOP   = 2'd0,
    MODE_FREEZE = 2'd1
  } mode_e;

  typedef struct packed {
    logic [2:0]  operation;
    logic [2:0]  anim_id;
    logic [3:0]  frame_slot;
    logic [15:0] elapsed_time;
    logic [15:0] duration;
    logic [11:0] frame_number;
    logic [15:0] user_tag;
    logic [1:0]  play_mode;
    logic [3:0]  loop_start;
    logic [3:0]  loop_end;
    logic [4:0]  frame_count;
  } in_t;

  typedef struct packed {
    logic        event_valid;
    logic [15:0] event_tag;
    logic [11:0] shown_frame;
    logic        playing;
    logic [2:0]  playing_id;
    logic [3:0]  frame_position;
  } out_t;

  // Frame entry as stored: duration, frame number, tag.
  typedef struct packed {
    logic [15:0] duration;
    logic [11:0] frame_number;
    logic [15:0] user_tag;
  } frame_t;

  typedef struct packed {
    logic [1:0] play_mode;
    logic [3:0] loop_start;
    logic [3:0] loop_end;
    logic [4:0] frame_count;
  } desc_t;

endpackage
`default_nettype wire

[hdl/sas_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
module sas_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

[hdl/sprite_animation_sequencer_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// Sprite animation sequencer.
// Input channel (in_valid_i/in_ready_o/in_data_i) carries one command beat:
// tick, play, stop, frame entry write or descriptor write. Every input beat
// yields exactly one output beat (out_valid_o/out_ready_i/out_data_o) that
// reports the event of a tick and the state after the command.
// Frame entries and descriptors live in two synchronous RAMs with registered
// read data. The sequencer works one beat at a time and walks frames by
// reading an entry, deciding, and reading the next. A write, play, stop or
// unknown beat passes S_DRD, S_DONE and S_OUT. A tick of a playing animation
// passes S_DRD, then S_FRD and S_EVAL for each frame looked at, then S_TAGW
// or S_DONE, then S_OUT. Once the result is taken, the next beat can be
// accepted in the cycle after. On a detected loop the accumulator is reduced
// modulo the cycle length in a sequential divider; in a transition walk
// outside loop mode it is reduced modulo the frame duration the same way.
// After reset no animation plays and the output is empty. The tables are
// undefined until written; no clearing pass is made. When the receiver stalls,
// the result stays in the output register and the next beat is held off
// until the result is taken.
module sprite_animation_sequencer_core #(
  parameter int unsigned NumAnimations = sas_pkg::NumAnimations,
  parameter int unsigned MaxFrames     = sas_pkg::MaxFrames
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire sas_pkg::in_t  in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output sas_pkg::out_t      out_data_o
);
  localparam int unsigned IdW   = (NumAnimations > 1) ? $clog2(NumAnimations) : 1;
  localparam int unsigned SlotW = (MaxFrames > 1) ? $clog2(MaxFrames) : 1;
  localparam int unsigned FrDepth = NumAnimations * MaxFrames;
  localparam int unsigned FrAw  = $clog2(FrDepth) > 0 ? $clog2(FrDepth) : 1;
  localparam int unsigned DsAw  = $clog2(NumAnimations) > 0 ? $clog2(NumAnimations) : 1;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_DRD    = 9'b000000010,  // descriptor read issued
    S_FRD    = 9'b000000100,  // frame entry read issued
    S_EVAL   = 9'b000001000,  // frame entry available
    S_DIV    = 9'b000010000,  // accumulator modulo running
    S_TAG    = 9'b000100000,  // remainder loaded into the accumulator
    S_TAGW   = 9'b001000000,
    S_DONE   = 9'b010000000,
    S_OUT    = 9'b100000000
  } state_e;

  state_e state_q, state_d;
  sas_pkg::in_t cmd_q;

  logic        act_v_q, que_v_q;
  logic [2:0]  act_id_q, que_id_q;
  logic [3:0]  pos_q;
  logic [31:0] acc_q;
  logic        trans_q;       // walk with queued animation
  logic        ev_q;
  logic [15:0] seen_q;
  logic [31:0] seen_acc_q [16];
  logic [31:0] div_d_q, div_r_q, div_n_q;
  logic [5:0]  div_cnt_q;
  logic        out_v_q;
  sas_pkg::out_t out_q;

  // Memories.
  logic            fr_we;
  logic [FrAw-1:0] fr_waddr, fr_raddr;
  logic [43:0]     fr_rdata;
  sas_pkg::frame_t fr_ent;
  logic            ds_we;
  logic [DsAw-1:0] ds_raddr;
  logic [14:0]     ds_rdata;
  sas_pkg::desc_t  desc;

  logic in_id_ok, in_slot_ok, pos_ok, act_ok;
  assign in_id_ok   = 32'(cmd_q.anim_id) < NumAnimations;
  assign in_slot_ok = 32'(cmd_q.frame_slot) < MaxFrames;
  assign act_ok     = 32'(act_id_q) < NumAnimations;
  assign pos_ok     = act_ok && (32'(pos_q) < MaxFrames);

  assign fr_we    = (state_q == S_DRD) && (cmd_q.operation == sas_pkg::OP_WRFR)
                    && in_id_ok && in_slot_ok;
  assign fr_waddr = FrAw'(32'(cmd_q.anim_id) * MaxFrames + 32'(cmd_q.frame_slot));
  assign fr_raddr = FrAw'(32'(act_id_q) * MaxFrames + 32'(pos_q));
  assign ds_we    = (state_q == S_DRD) && (cmd_q.operation == sas_pkg::OP_WRDS)
                    && in_id_ok;
  assign ds_raddr = DsAw'(act_id_q);

  sas_ram #(.Width(44), .Depth(FrDepth)) u_frame_ram (
    .clk_i, .we_i(fr_we), .waddr_i(fr_waddr),
    .wdata_i({cmd_q.duration, cmd_q.frame_number, cmd_q.user_tag}),
    .raddr_i(fr_raddr), .rdata_o(fr_rdata)
  );
  sas_ram #(.Width(15), .Depth(NumAnimations)) u_desc_ram (
    .clk_i, .we_i(ds_we), .waddr_i(DsAw'(cmd_q.anim_id)),
    .wdata_i({cmd_q.play_mode, cmd_q.loop_start, cmd_q.loop_end, cmd_q.frame_count}),
    .raddr_i(ds_raddr), .rdata_o(ds_rdata)
  );

  // Out-of-range positions read as an all-zero entry.
  logic pos_ok_q;
  assign fr_ent = pos_ok_q ? sas_pkg::frame_t'(fr_rdata) : '0;
  assign desc   = sas_pkg::desc_t'(ds_rdata);

  assign in_ready_o  = (state_q == S_IDLE) && !out_v_q;
  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  // Walk decision, evaluated in S_EVAL.
  logic [31:0] dur;
  logic [4:0]  pos_p1;
  logic        last;
  logic [3:0]  nxt;
  logic [31:0] cyc;
  assign dur    = {16'd0, fr_ent.duration};
  assign pos_p1 = {1'b0, pos_q} + 5'd1;
  assign last   = pos_p1 >= desc.frame_count;
  assign cyc    = seen_acc_q[pos_q] - acc_q;

  // Next position of the transition walk in loop mode. It may reach 16, one
  // past the table, where the entry reads as zero.
  logic [4:0]  skip_pos;
  logic [4:0]  skip_p1;
  assign skip_pos = (pos_q <= desc.loop_end) ? ({1'b0, desc.loop_end} + 5'd1) : pos_p1;
  assign skip_p1  = skip_pos + 5'd1;

  always_comb begin
    unique case (desc.play_mode)
      sas_pkg::MODE_LOOP:
        nxt = (pos_q == desc.loop_end) ? desc.loop_start : pos_p1[3:0];
      sas_pkg::MODE_FREEZE:
        nxt = (pos_p1 == desc.frame_count) ? pos_q : pos_p1[3:0];
      default: nxt = pos_q;
    endcase
  end

  logic [32:0] sum;
  assign sum = {1'b0, acc_q} + {17'd0, cmd_q.elapsed_time};

  logic [32:0] div_sub;
  assign div_sub = {div_r_q, div_n_q[31]} - {1'b0, div_d_q};

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i && in_ready_o) begin
      cmd_q <= in_data_i;
    end
    pos_ok_q <= pos_ok;
    if (state_q == S_EVAL && !trans_q && dur != 32'd0 && acc_q >= dur
        && !seen_q[pos_q]) begin
      seen_acc_q[pos_q] <= acc_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      act_v_q   <= 1'b0;
      que_v_q   <= 1'b0;
      act_id_q  <= '0;
      que_id_q  <= '0;
      pos_q     <= '0;
      acc_q     <= '0;
      trans_q   <= 1'b0;
      ev_q      <= 1'b0;
      seen_q    <= '0;
      div_d_q   <= '0;
      div_r_q   <= '0;
      div_n_q   <= '0;
      div_cnt_q <= '0;
      out_v_q   <= 1'b0;
      out_q     <= '0;
    end else begin
      if (out_v_q && out_ready_i) begin
        out_v_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i && in_ready_o) begin
            state_q <= S_DRD;
          end
        end
        S_DRD: begin
          ev_q   <= 1'b0;
          seen_q <= '0;
          state_q <= (cmd_q.operation == sas_pkg::OP_TICK && act_v_q) ? S_FRD : S_DONE;
          case (cmd_q.operation)
            sas_pkg::OP_TICK: begin
              if (act_v_q) begin
                acc_q   <= sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                trans_q <= que_v_q;
              end
            end
            sas_pkg::OP_PLAY: begin
              if (in_id_ok && !(act_v_q && act_id_q == cmd_q.anim_id)
                  && !(que_v_q && que_id_q == cmd_q.anim_id)) begin
                if (act_v_q) begin
                  que_v_q  <= 1'b1;
                  que_id_q <= cmd_q.anim_id;
                end else begin
                  act_v_q  <= 1'b1;
                  act_id_q <= cmd_q.anim_id;
                  que_v_q  <= 1'b0;
                  que_id_q <= '0;
                  pos_q    <= '0;
                  acc_q    <= '0;
                end
              end
            end
            sas_pkg::OP_STOP: begin
              act_v_q  <= 1'b0;
              act_id_q <= '0;
              que_v_q  <= 1'b0;
              que_id_q <= '0;
              pos_q    <= '0;
              acc_q    <= '0;
            end
            default: ;
          endcase
        end
        S_FRD: state_q <= S_EVAL;
        S_EVAL: begin
          if (!trans_q) begin
            if (dur == 32'd0 || acc_q < dur) begin
              // First look is the event test; the walk ends here too.
              if (!ev_q && acc_q < dur) begin
                state_q <= S_DONE;
              end else begin
                ev_q    <= 1'b1;
                state_q <= S_TAGW;
              end
            end else if (seen_q[pos_q]) begin
              ev_q   <= 1'b1;
              seen_q <= '0;
              if (cyc != 32'd0) begin
                div_d_q   <= cyc;
                div_n_q   <= acc_q;
                div_r_q   <= '0;
                div_cnt_q <= 6'd32;
                state_q   <= S_DIV;
              end else begin
                state_q <= S_FRD;
              end
            end else begin
              ev_q      <= 1'b1;
              seen_q[pos_q] <= 1'b1;
              acc_q     <= acc_q - dur;
              pos_q     <= nxt;
              state_q   <= S_FRD;
            end
          end else begin
            // Transition walk; the first look also settles the event.
            if (!ev_q && acc_q < dur) begin
              state_q <= S_DONE;
            end else begin
              ev_q <= 1'b1;
              if (last) begin
                act_id_q <= que_id_q;
                que_v_q  <= 1'b0;
                que_id_q <= '0;
                pos_q    <= '0;
                acc_q    <= '0;
                state_q  <= S_TAGW;
              end else if (dur == 32'd0 || acc_q < dur) begin
                state_q <= S_TAGW;
              end else if (desc.play_mode != sas_pkg::MODE_LOOP) begin
                div_d_q   <= dur;
                div_n_q   <= acc_q;
                div_r_q   <= '0;
                div_cnt_q <= 6'd32;
                state_q   <= S_DIV;
              end else if (skip_p1 >= desc.frame_count) begin
                // The step lands on the last frame: the queued one takes over.
                act_id_q <= que_id_q;
                que_v_q  <= 1'b0;
                que_id_q <= '0;
                pos_q    <= '0;
                acc_q    <= '0;
                state_q  <= S_TAGW;
              end else if (skip_pos[4]) begin
                // Past the table the entry reads as zero, so the walk stops
                // there and the position counter wraps to 0.
                acc_q   <= acc_q - dur;
                pos_q   <= '0;
                state_q <= S_TAGW;
              end else begin
                acc_q   <= acc_q - dur;
                pos_q   <= skip_pos[3:0];
                state_q <= S_FRD;
              end
            end
          end
        end
        S_DIV: begin
          // Restoring divider, one quotient bit per cycle; remainder kept.
          if (div_sub[32]) begin
            div_r_q <= {div_r_q[30:0], div_n_q[31]};
          end else begin
            div_r_q <= div_sub[31:0];
          end
          div_n_q   <= {div_n_q[30:0], 1'b0};
          div_cnt_q <= div_cnt_q - 6'd1;
          if (div_cnt_q == 6'd1) begin
            state_q <= S_TAG;
          end
        end
        S_TAG: begin
          acc_q   <= div_r_q;
          state_q <= trans_q ? S_TAGW : S_FRD;
        end
        S_TAGW: state_q <= S_OUT;
        S_DONE: state_q <= S_OUT;
        S_OUT: begin
          // Frame and descriptor read addresses have settled by now.
          out_v_q <= 1'b1;
          out_q.event_valid    <= ev_q;
          out_q.event_tag      <= ev_q ? fr_ent.user_tag : 16'd0;
          out_q.shown_frame    <= act_v_q ? fr_ent.frame_number : 12'd0;
          out_q.playing        <= act_v_q;
          out_q.playing_id     <= act_v_q ? act_id_q : 3'd0;
          out_q.frame_position <= act_v_q ? pos_q : 4'd0;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  logic unused;
  assign unused = ^{IdW, SlotW, state_d};
  assign state_d = state_q;
endmodule
`default_nettype wire

[test/sprite_animation_sequencer_core_tb.sv]
`timescale 1ns / 1ps
module sprite_animation_sequencer_core_tb;
  import sas_pkg::*;

  localparam logic [1:0] MODE_HOLD     = 2'd2;
  localparam logic [1:0] MODE_HOLD_ALT = 2'd3;
  localparam int unsigned CYCLE_LIMIT  = 1500000;

  typedef struct {
    in_t beat;
    int  idle_pct;
    int  stall_pct;
    bit  drain;
  } pending_t;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  in_t  in_data_i;
  logic out_valid_o;
  logic out_ready_i;
  out_t out_data_o;

  pending_t pending_beats[$];
  out_t     expected_results[$];
  int       error_count;
  int       stall_pct;
  bit       in_fire;
  int unsigned cycle_count;

  // Predictor state.
  frame_t      frame_mem[NumAnimations][MaxFrames];
  desc_t       desc_mem[NumAnimations];
  bit          seq_active;
  logic [2:0]  seq_id;
  bit          seq_queued;
  logic [2:0]  seq_queued_id;
  logic [3:0]  seq_pos;
  logic [31:0] seq_acc;

  sprite_animation_sequencer_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  // Duration of an entry; positions past the table read as zero.
  function automatic logic [31:0] entry_duration(logic [2:0] id, int pos);
    if (pos >= MaxFrames) return 32'd0;
    return {16'd0, frame_mem[id][pos].duration};
  endfunction

  function automatic logic [3:0] next_position(int pos);
    desc_t ds;
    ds = desc_mem[seq_id];
    if (ds.play_mode == MODE_LOOP)
      return (pos == ds.loop_end) ? ds.loop_start : 4'((pos + 1) & 15);
    if (ds.play_mode == MODE_FREEZE)
      return (pos + 1 == ds.frame_count) ? 4'(pos) : 4'((pos + 1) & 15);
    return 4'(pos);
  endfunction

  // Plain advance: step frames while the accumulator covers the duration.
  // Revisiting a position means a cycle, so the accumulator is cut down by
  // the time that one lap takes.
  function automatic void walk_frames();
    logic [31:0] lap_acc[16];
    bit          visited[16];
    logic [31:0] dur;
    logic [31:0] lap;
    int          p;
    foreach (visited[i]) visited[i] = 1'b0;
    while (1) begin
      dur = entry_duration(seq_id, seq_pos);
      p = seq_pos;
      if (dur == 0 || seq_acc < dur) break;
      if (visited[p]) begin
        lap = lap_acc[p] - seq_acc;
        if (lap != 0) seq_acc = seq_acc % lap;
        foreach (visited[i]) visited[i] = 1'b0;
        continue;
      end
      visited[p] = 1'b1;
      lap_acc[p] = seq_acc;
      seq_acc = seq_acc - dur;
      seq_pos = next_position(p);
    end
  endfunction

  // Advance with an animation waiting: in loop mode skip past the loop range,
  // else cut the accumulator modulo the duration; hand over at the last frame.
  function automatic void walk_to_handover();
    desc_t       ds;
    int          n;
    int          pos;
    logic [31:0] dur;
    ds = desc_mem[seq_id];
    n = ds.frame_count;
    pos = seq_pos;
    if (pos + 1 < n) begin
      while (1) begin
        dur = entry_duration(seq_id, pos);
        if (dur == 0 || seq_acc < dur || pos + 1 >= n) break;
        if (ds.play_mode != MODE_LOOP) begin
          seq_acc = seq_acc % dur;
          break;
        end
        seq_acc = seq_acc - dur;
        pos = (pos <= ds.loop_end) ? ds.loop_end + 1 : pos + 1;
      end
    end
    if (pos + 1 >= n) begin
      seq_id = seq_queued_id;
      seq_queued = 1'b0;
      seq_queued_id = '0;
      seq_pos = '0;
      seq_acc = '0;
    end else begin
      seq_pos = 4'(pos & 15);
    end
  endfunction

  function automatic void clear_playback();
    seq_active = 1'b0;
    seq_id = '0;
    seq_queued = 1'b0;
    seq_queued_id = '0;
    seq_pos = '0;
    seq_acc = '0;
  endfunction

  function automatic out_t sequence_beat(in_t b);
    out_t        r;
    logic [32:0] sum;
    r = '0;
    case (b.operation)
      OP_TICK: begin
        if (seq_active) begin
          sum = {1'b0, seq_acc} + b.elapsed_time;
          seq_acc = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
          if (seq_acc >= entry_duration(seq_id, seq_pos)) begin
            if (!seq_queued) walk_frames();
            else walk_to_handover();
            r.event_valid = 1'b1;
            r.event_tag = frame_mem[seq_id][seq_pos].user_tag;
          end
        end
      end
      OP_PLAY: begin
        if (!(seq_active && seq_id == b.anim_id) &&
            !(seq_queued && seq_queued_id == b.anim_id)) begin
          if (seq_active) begin
            seq_queued = 1'b1;
            seq_queued_id = b.anim_id;
          end else begin
            clear_playback();
            seq_active = 1'b1;
            seq_id = b.anim_id;
          end
        end
      end
      OP_STOP: clear_playback();
      OP_WRFR: begin
        frame_mem[b.anim_id][b.frame_slot] = {b.duration, b.frame_number, b.user_tag};
      end
      OP_WRDS: begin
        desc_mem[b.anim_id] = {b.play_mode, b.loop_start, b.loop_end, b.frame_count};
      end
      default: ;
    endcase
    if (seq_active) begin
      r.shown_frame = frame_mem[seq_id][seq_pos].frame_number;
      r.playing = 1'b1;
      r.playing_id = seq_id;
      r.frame_position = seq_pos;
    end
    return r;
  endfunction

  task automatic report_mismatch(string field, int got, int want);
    $display("MISMATCH %s: got %0d, expected %0d at %0t", field, got, want, $realtime);
    error_count++;
  endtask

  // Driver: inputs move at the falling edge.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      out_ready_i <= ($urandom_range(99) >= stall_pct);
      if (!in_valid_i || in_fire) begin
        if (pending_beats.size() == 0 ||
            (pending_beats[0].drain && expected_results.size() != 0) ||
            $urandom_range(99) < pending_beats[0].idle_pct) begin
          in_valid_i <= 1'b0;
        end else begin
          in_data_i  <= pending_beats[0].beat;
          stall_pct  <= pending_beats[0].stall_pct;
          in_valid_i <= 1'b1;
          void'(pending_beats.pop_front());
        end
      end
    end
  end

  // Monitor: accepted input beats feed the predictor, output beats are checked.
  always @(posedge clk_i) begin
    out_t want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
    in_fire <= rst_ni && in_valid_i && in_ready_o;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) expected_results.push_back(sequence_beat(in_data_i));
      if (out_valid_o && out_ready_i) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected output beat", 1, 0);
        end else begin
          want = expected_results.pop_front();
          if (out_data_o.event_valid !== want.event_valid)
            report_mismatch("event_valid", out_data_o.event_valid, want.event_valid);
          if (out_data_o.event_tag !== want.event_tag)
            report_mismatch("event_tag", out_data_o.event_tag, want.event_tag);
          if (out_data_o.shown_frame !== want.shown_frame)
            report_mismatch("shown_frame", out_data_o.shown_frame, want.shown_frame);
          if (out_data_o.playing !== want.playing)
            report_mismatch("playing", out_data_o.playing, want.playing);
          if (out_data_o.playing_id !== want.playing_id)
            report_mismatch("playing_id", out_data_o.playing_id, want.playing_id);
          if (out_data_o.frame_position !== want.frame_position)
            report_mismatch("frame_position", out_data_o.frame_position,
                            want.frame_position);
        end
      end
    end
  end

  // Beat with every field random, then the meaningful ones set by the caller.
  function automatic in_t noise_beat(logic [2:0] op);
    in_t b;
    b = in_t'({$urandom, $urandom, $urandom});
    b.operation = op;
    return b;
  endfunction

  function automatic logic [15:0] pick_duration();
    int sel;
    sel = $urandom_range(99);
    if (sel < 8) return 16'd0;
    if (sel < 75) return 16'($urandom_range(64, 1));
    return 16'($urandom);
  endfunction

  function automatic logic [15:0] pick_elapsed();
    int sel;
    sel = $urandom_range(99);
    if (sel < 10) return 16'd0;
    if (sel < 85) return 16'($urandom_range(150));
    return 16'($urandom);
  endfunction

  task automatic queue_beat(in_t b, int idle, int stall, bit drain = 1'b0);
    pending_t e;
    e.beat = b;
    e.idle_pct = idle;
    e.stall_pct = stall;
    e.drain = drain;
    pending_beats.push_back(e);
  endtask

  task automatic queue_frame(int id, int slot, logic [15:0] dur, int idle, int stall);
    in_t b;
    b = noise_beat(OP_WRFR);
    b.anim_id = 3'(id);
    b.frame_slot = 4'(slot);
    b.duration = dur;
    queue_beat(b, idle, stall);
  endtask

  task automatic queue_desc(int id, logic [1:0] mode, int ls, int le, int cnt,
                            int idle, int stall);
    in_t b;
    b = noise_beat(OP_WRDS);
    b.anim_id = 3'(id);
    b.play_mode = mode;
    b.loop_start = 4'(ls);
    b.loop_end = 4'(le);
    b.frame_count = 5'(cnt);
    queue_beat(b, idle, stall);
  endtask

  task automatic queue_cmd(logic [2:0] op, int id, logic [15:0] elapsed,
                           int idle, int stall, bit drain = 1'b0);
    in_t b;
    b = noise_beat(op);
    b.anim_id = 3'(id);
    b.elapsed_time = elapsed;
    queue_beat(b, idle, stall, drain);
  endtask

  task automatic queue_random_desc(int id, int idle, int stall);
    int cnt;
    cnt = ($urandom_range(9) == 0) ? $urandom_range(31) : $urandom_range(16, 1);
    queue_desc(id, 2'($urandom_range(3)), $urandom_range(15), $urandom_range(15), cnt,
               idle, stall);
  endtask

  initial begin
    int idle;
    int stall;
    int sel;
    error_count = 0;
    cycle_count = 0;
    stall_pct = 0;
    in_fire = 1'b0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    out_ready_i = 1'b1;
    clear_playback();

    // Load every table entry before anything can read one.
    for (int a = 0; a < NumAnimations; a++) begin
      queue_random_desc(a, 0, 0);
      for (int s = 0; s < MaxFrames; s++) queue_frame(a, s, pick_duration(), 0, 0);
    end

    // Directed part: boundary fields, every command and the odd cases.
    queue_cmd(OP_TICK, 0, 16'hFFFF, 0, 0);               // tick while idle
    queue_desc(0, MODE_LOOP, 2, 5, 8, 0, 0);
    queue_cmd(OP_PLAY, 0, 0, 0, 0);
    queue_cmd(OP_TICK, 0, 16'd0, 0, 0);
    queue_cmd(OP_TICK, 0, 16'hFFFF, 0, 0);               // long walk, loop cut
    queue_cmd(OP_PLAY, 0, 0, 0, 0);                      // play of active one
    queue_cmd(OP_PLAY, 7, 0, 0, 0);                      // queued
    queue_cmd(OP_PLAY, 7, 0, 0, 0);                      // play of queued one
    queue_desc(7, MODE_FREEZE, 0, 15, 16, 0, 0);
    queue_cmd(OP_TICK, 0, 16'd500, 0, 0);                // handover
    queue_cmd(OP_TICK, 0, 16'hFFFF, 0, 0);               // freeze on last frame
    queue_cmd(3'($urandom_range(7, 5)), 7, 0, 0, 0);     // unknown command
    queue_cmd(3'd7, 7, 0, 0, 0);
    queue_desc(3, MODE_LOOP, 15, 15, 17, 0, 0);          // loop end past last
    queue_cmd(OP_PLAY, 3, 0, 0, 0);
    queue_cmd(OP_TICK, 0, 16'd4000, 0, 0);
    queue_cmd(OP_STOP, 0, 0, 0, 0);
    queue_desc(4, MODE_HOLD_ALT, 0, 0, 0, 0, 0);         // zero count, hold
    queue_cmd(OP_PLAY, 4, 0, 0, 0);
    queue_frame(4, 0, 16'd0, 0, 0);                      // hold forever
    queue_cmd(OP_TICK, 0, 16'hFFFF, 0, 0);
    queue_desc(5, MODE_HOLD, 0, 0, 31, 0, 0);
    queue_cmd(OP_PLAY, 5, 0, 0, 0);
    queue_cmd(OP_TICK, 0, 16'd300, 0, 0);
    queue_cmd(OP_STOP, 0, 0, 0, 0, 1'b1);                // sender waits for drain

    // Random part in four idling phases.
    for (int i = 0; i < 1850; i++) begin
      case (i * 4 / 1850)
        0: begin idle = 0;  stall = 0;  end
        1: begin idle = 51; stall = 0;  end
        2: begin idle = 0;  stall = 51; end
        default: begin idle = 19; stall = 19; end
      endcase
      sel = $urandom_range(99);
      if (sel < 60) queue_cmd(OP_TICK, 0, pick_elapsed(), idle, stall, (i % 400) == 399);
      else if (sel < 72) queue_cmd(OP_PLAY, $urandom_range(7), 0, idle, stall);
      else if (sel < 76) queue_cmd(OP_STOP, 0, 0, idle, stall);
      else if (sel < 88)
        queue_frame($urandom_range(7), $urandom_range(15), pick_duration(), idle, stall);
      else if (sel < 97) queue_random_desc($urandom_range(7), idle, stall);
      else queue_cmd(3'($urandom_range(7, 5)), 0, 0, idle, stall);
    end

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    wait (pending_beats.size() == 0 && !in_valid_i && expected_results.size() == 0);
    repeat (200) @(posedge clk_i);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/sas_pkg.sv
hdl/sas_ram.sv
hdl/sprite_animation_sequencer_core.sv
test/sprite_animation_sequencer_core_tb.sv
